[sv/nlmwa_pkg.sv]
package nlmwa_pkg;

    // input command codes, carried in s_tuser
    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_PAIR   = 2'd1,
        CMD_CLOSE  = 2'd2,
        CMD_FINISH = 2'd3
    } cmd_t;

    // configuration register indexes
    localparam logic [3:0] CFG_PATCH_DIFF_SCALE = 4'd0;
    localparam logic [3:0] CFG_WEIGHT_THRESHOLD = 4'd1;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 20;

    localparam logic [19:0] SCALE_RESET     = 20'd58254;
    localparam logic [16:0] THRESHOLD_RESET = 17'd6554;

    localparam int MAX_CANDIDATES_DEF = 4096;
    localparam int TAKEN_HW_MAX       = 8191;

    localparam int PIX_W   = 8;
    localparam int SSD_W   = 24;
    localparam int SCALE_W = 20;
    localparam int PROD_W  = SSD_W + SCALE_W;
    localparam int W_W     = 17;
    localparam int VSUM_W  = 40;
    localparam int WSUM_W  = 32;
    localparam int TAKEN_W = 13;
    localparam int NUM_W   = VSUM_W + 1;
    localparam int QUOT_W  = 9;

    localparam int EXP_DEPTH = 590;
    localparam int EXP_IDX_W = $clog2(EXP_DEPTH);

    localparam logic [63:0] EXP_STEP_Q30 = 64'd1069555701;
    localparam logic [63:0] ONE_Q30      = 64'd1073741824;

    typedef logic [W_W-1:0] exp_rom_t [0:EXP_DEPTH-1];

    // exp(-k/256) in Q16, stepped in Q30 with rounding at each step
    function automatic exp_rom_t build_exp_table();
        exp_rom_t    t;
        logic [63:0] acc;
        acc = ONE_Q30;
        for (int k = 0; k < EXP_DEPTH; k++) begin
            t[k] = W_W'((acc + 64'd8192) >> 14);
            acc  = (acc * EXP_STEP_Q30 + 64'd536870912) >> 30;
        end
        return t;
    endfunction

    localparam exp_rom_t EXP_TABLE = build_exp_table();

    // controller to datapath commands
    typedef struct packed {
        logic       start_load;
        logic       ssd_acc;
        logic       close_begin;
        logic       close_lut;
        logic       close_acc;
        logic       div_start;
        logic [1:0] div_ch;
        logic       out_load;
        logic [1:0] out_ch;
    } ctl_cmd_t;

endpackage

[sv/nlm_patch_weighted_average_top.sv]
// Start and pixel-pair requests are accepted back to back.
// A close request runs the product, the exp table read and the weighted add in turn.
// A finish request divides the three channels in turn on one radix-2 divider;
// the result shows once the last channel has been divided.
// Reset (aresetn low, synchronous) clears all sums and counts and reloads the
// configuration defaults; no memory needs clearing.
module nlm_patch_weighted_average_top #(
    parameter int MAX_CANDIDATES = nlmwa_pkg::MAX_CANDIDATES_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // a_red, a_green, a_blue, b_red, b_green, b_blue
    input  logic [47:0]                        s_tdata,
    // cmd
    input  logic [1:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // out_red, out_green, out_blue, candidates_taken, 3 zero bits
    output logic [39:0]                        m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [nlmwa_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [nlmwa_pkg::CFG_DATA_W-1:0]   cfg_data
);

    nlmwa_pkg::ctl_cmd_t              ctl;
    logic                             div_done;
    logic [nlmwa_pkg::NUM_W-1:0]      div_num;
    logic [nlmwa_pkg::WSUM_W-1:0]     div_den;
    logic [nlmwa_pkg::QUOT_W-1:0]     div_quot;
    logic [2:0][7:0]                  pix_a;
    logic [2:0][7:0]                  pix_b;
    logic [2:0][7:0]                  out_pix;
    logic [nlmwa_pkg::TAKEN_W-1:0]    out_taken;

    assign pix_a     = s_tdata[23:0];
    assign pix_b     = s_tdata[47:24];
    assign cfg_ready = 1'b1;
    assign m_tdata   = {3'd0, out_taken, out_pix};

    nlmwa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_cmd    (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .div_done (div_done),
        .ctl      (ctl)
    );

    nlmwa_dp #(
        .MAX_CANDIDATES (MAX_CANDIDATES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .pix_a     (pix_a),
        .pix_b     (pix_b),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .div_num   (div_num),
        .div_den   (div_den),
        .div_quot  (div_quot),
        .out_pix   (out_pix),
        .out_taken (out_taken)
    );

    nlmwa_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ctl.div_start),
        .num     (div_num),
        .den     (div_den),
        .quot    (div_quot),
        .done    (div_done)
    );

endmodule

[sv/nlmwa_div.sv]
module nlmwa_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [nlmwa_pkg::NUM_W-1:0]    num,
    input  logic [nlmwa_pkg::WSUM_W-1:0]   den,
    output logic [nlmwa_pkg::QUOT_W-1:0]   quot,
    output logic                           done
);

    localparam int NW = nlmwa_pkg::NUM_W;
    localparam int QW = nlmwa_pkg::QUOT_W;

    logic [NW-1:0] rem_reg;
    logic [NW-1:0] den_reg;
    logic [QW-1:0] q_reg;
    logic [3:0]    cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic          ge;

    assign ge = (rem_reg >= den_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= busy_reg && cnt_reg == 4'd0 && !start;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == 4'd0) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // one quotient bit per cycle, top bit flags an overflow past 255
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num;
            den_reg <= NW'({den, 8'd0});
            q_reg   <= '0;
            cnt_reg <= 4'(QW - 1);
        end else if (busy_reg) begin
            if (ge) begin
                rem_reg <= rem_reg - den_reg;
            end
            q_reg   <= {q_reg[QW-2:0], ge};
            den_reg <= den_reg >> 1;
            cnt_reg <= cnt_reg - 4'd1;
        end
    end

    assign quot = q_reg;
    assign done = done_reg;

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider restarted while busy");

    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");

    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy_reg && !done_reg)
        else $error("divider did not begin after start");

endmodule

[sv/nlmwa_dp.sv]
module nlmwa_dp #(
    parameter int MAX_CANDIDATES = nlmwa_pkg::MAX_CANDIDATES_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  nlmwa_pkg::ctl_cmd_t                   ctl,
    input  logic [2:0][7:0]                       pix_a,
    input  logic [2:0][7:0]                       pix_b,
    input  logic                                  cfg_we,
    input  logic [nlmwa_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [nlmwa_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic [nlmwa_pkg::NUM_W-1:0]           div_num,
    output logic [nlmwa_pkg::WSUM_W-1:0]          div_den,
    input  logic [nlmwa_pkg::QUOT_W-1:0]          div_quot,
    output logic [2:0][7:0]                       out_pix,
    output logic [nlmwa_pkg::TAKEN_W-1:0]         out_taken
);

    localparam int SW = nlmwa_pkg::SSD_W;
    localparam int PW = nlmwa_pkg::PROD_W;
    localparam int WW = nlmwa_pkg::W_W;
    localparam int VW = nlmwa_pkg::VSUM_W;
    localparam int GW = nlmwa_pkg::WSUM_W;
    localparam int TW = nlmwa_pkg::TAKEN_W;
    localparam int LIMIT_INT = (MAX_CANDIDATES > nlmwa_pkg::TAKEN_HW_MAX) ?
                               nlmwa_pkg::TAKEN_HW_MAX : MAX_CANDIDATES;
    localparam logic [TW-1:0] TAKEN_LIMIT = TW'(LIMIT_INT);

    logic [nlmwa_pkg::SCALE_W-1:0] scale_reg;
    logic [WW-1:0]                 thresh_reg;
    logic [SW-1:0]                 ssd_reg;
    logic [2:0][VW-1:0]            vsum_reg;
    logic [GW-1:0]                 wsum_reg;
    logic [TW-1:0]                 taken_reg;
    logic [PW-1:0]                 prod_reg;
    logic [2:0][7:0]               cand_reg;
    logic [WW-1:0]                 w_reg;
    logic [2:0][7:0]               out_reg;
    logic [TW-1:0]                 out_taken_reg;

    logic [17:0]        pair_d;
    logic [SW:0]        ssd_sum;
    logic [PW-1:0]      arg_full;
    logic [2:0][VW:0]   vsum_add;
    logic [GW:0]        wsum_add;
    logic               w_pass;
    logic [7:0]         quot_sat;

    always_comb begin
        logic [7:0] diff;
        pair_d = '0;
        for (int c = 0; c < 3; c++) begin
            diff   = (pix_a[c] > pix_b[c]) ? pix_a[c] - pix_b[c] : pix_b[c] - pix_a[c];
            pair_d = pair_d + 18'(16'(diff) * 16'(diff));
        end
    end

    assign ssd_sum  = {1'b0, ssd_reg} + (SW + 1)'(pair_d);
    assign arg_full = (prod_reg + PW'(2048)) >> 12;
    assign w_pass   = ({1'b0, w_reg} >= {1'b0, thresh_reg});
    assign wsum_add = {1'b0, wsum_reg} + (GW + 1)'(w_reg);

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            vsum_add[c] = {1'b0, vsum_reg[c]} + (VW + 1)'(25'(w_reg) * 25'(cand_reg[c]));
        end
    end

    always_comb begin
        case (ctl.div_ch)
            2'd1:    div_num = {1'b0, vsum_reg[1]} + (VW + 1)'(wsum_reg >> 1);
            2'd2:    div_num = {1'b0, vsum_reg[2]} + (VW + 1)'(wsum_reg >> 1);
            default: div_num = {1'b0, vsum_reg[0]} + (VW + 1)'(wsum_reg >> 1);
        endcase
    end
    assign div_den = wsum_reg;

    always_comb begin
        if (wsum_reg == '0) begin
            quot_sat = 8'd0;
        end else if (div_quot[nlmwa_pkg::QUOT_W-1]) begin
            quot_sat = 8'd255;
        end else begin
            quot_sat = div_quot[7:0];
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg  <= nlmwa_pkg::SCALE_RESET;
            thresh_reg <= nlmwa_pkg::THRESHOLD_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                nlmwa_pkg::CFG_PATCH_DIFF_SCALE: scale_reg  <= cfg_data;
                nlmwa_pkg::CFG_WEIGHT_THRESHOLD: thresh_reg <= cfg_data[WW-1:0];
                default: ;
            endcase
        end
    end

    // accumulators
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ssd_reg   <= '0;
            vsum_reg  <= '0;
            wsum_reg  <= '0;
            taken_reg <= '0;
        end else begin
            if (ctl.start_load) begin
                for (int c = 0; c < 3; c++) begin
                    vsum_reg[c] <= VW'({pix_a[c], 16'd0});
                end
                wsum_reg  <= GW'(65536);
                ssd_reg   <= '0;
                taken_reg <= '0;
            end
            if (ctl.ssd_acc) begin
                ssd_reg <= ssd_sum[SW] ? {SW{1'b1}} : ssd_sum[SW-1:0];
            end
            if (ctl.close_begin) begin
                ssd_reg <= '0;
            end
            if (ctl.close_acc && w_pass) begin
                for (int c = 0; c < 3; c++) begin
                    vsum_reg[c] <= vsum_add[c][VW] ? {VW{1'b1}} : vsum_add[c][VW-1:0];
                end
                wsum_reg <= wsum_add[GW] ? {GW{1'b1}} : wsum_add[GW-1:0];
                if (taken_reg < TAKEN_LIMIT) begin
                    taken_reg <= taken_reg + TW'(1);
                end
            end
        end
    end

    // close pipeline and result registers
    always_ff @(posedge aclk) begin
        if (ctl.close_begin) begin
            prod_reg <= PW'(ssd_reg) * PW'(scale_reg);
            cand_reg <= pix_a;
        end
        if (ctl.close_lut) begin
            w_reg <= (arg_full < PW'(nlmwa_pkg::EXP_DEPTH)) ?
                     nlmwa_pkg::EXP_TABLE[arg_full[nlmwa_pkg::EXP_IDX_W-1:0]] : '0;
        end
        if (ctl.out_load) begin
            case (ctl.out_ch)
                2'd1:    out_reg[1] <= quot_sat;
                2'd2:    out_reg[2] <= quot_sat;
                default: out_reg[0] <= quot_sat;
            endcase
            out_taken_reg <= taken_reg;
        end
    end

    assign out_pix   = out_reg;
    assign out_taken = out_taken_reg;

    a_taken_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        taken_reg <= TAKEN_LIMIT)
        else $error("accepted count ran past its limit");

    a_ssd_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.close_begin |=> ssd_reg == '0)
        else $error("patch difference sum not cleared on close");

    a_wsum_start: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.start_load |=> wsum_reg == GW'(65536) && taken_reg == '0)
        else $error("start did not load unit weight");

endmodule

[sv/nlmwa_ctrl.sv]
module nlmwa_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [1:0]           s_cmd,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic                 div_done,
    output nlmwa_pkg::ctl_cmd_t  ctl
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CL_LUT,
        ST_CL_ACC,
        ST_DIV
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] ch_reg, ch_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic       accept;

    // hold a second finish until the previous result is taken
    assign s_tready = (state_reg == ST_IDLE) &&
                      !(s_cmd == nlmwa_pkg::CMD_FINISH && m_tvalid_reg);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next    = state_reg;
        ch_next       = ch_reg;
        m_tvalid_next = m_tvalid_reg;
        ctl           = '0;
        ctl.div_ch    = ch_reg;
        ctl.out_ch    = ch_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_cmd)
                        nlmwa_pkg::CMD_START: ctl.start_load = 1'b1;
                        nlmwa_pkg::CMD_PAIR:  ctl.ssd_acc    = 1'b1;
                        nlmwa_pkg::CMD_CLOSE: begin
                            ctl.close_begin = 1'b1;
                            state_next      = ST_CL_LUT;
                        end
                        nlmwa_pkg::CMD_FINISH: begin
                            ctl.div_start = 1'b1;
                            ctl.div_ch    = 2'd0;
                            ch_next       = 2'd0;
                            state_next    = ST_DIV;
                        end
                        default: ;
                    endcase
                end
            end
            ST_CL_LUT: begin
                ctl.close_lut = 1'b1;
                state_next    = ST_CL_ACC;
            end
            ST_CL_ACC: begin
                ctl.close_acc = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_DIV: begin
                if (div_done) begin
                    ctl.out_load = 1'b1;
                    if (ch_reg == 2'd2) begin
                        m_tvalid_next = 1'b1;
                        state_next    = ST_IDLE;
                    end else begin
                        // advance to the next channel
                        ch_next       = ch_reg + 2'd1;
                        ctl.div_start = 1'b1;
                        ctl.div_ch    = ch_reg + 2'd1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ch_reg       <= 2'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ch_reg       <= ch_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    a_busy_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("request accepted while busy");

    a_close_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CL_LUT |=> state_reg == ST_CL_ACC)
        else $error("close sequence broken");

    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DIV && div_done && ch_reg == 2'd2))
        else $error("result raised outside the divide sequence");

    a_div_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> !m_tvalid_reg)
        else $error("result overwritten while waiting");

endmodule
